FILE: rtl/sqdpcm_pkg.sv
// sqdpcm_pkg: shared types, constants and helpers of the square-step dpcm encoder
// depends on nothing; imported by every module under rtl/
`timescale 1ns / 1ps

package sqdpcm_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 7;
    localparam int CODE_W   = 8;
    localparam int MAG_W    = 17;
    localparam int SQ_W     = 2 * IDX_W;
    localparam int SUM_W    = SAMPLE_W + 2;
    localparam int BIT_W    = $clog2(IDX_W);

    // magnitudes at or above this limit quantize to the top index
    localparam logic [MAG_W-1:0] MAX_DIFF = 17'd16384;
    // smallest magnitude whose nearest square root is 128 (then clamped)
    localparam logic [MAG_W-1:0] ROOT_CLAMP_THR = 17'd16257;
    localparam logic [IDX_W-1:0] IDX_MAX = 7'd127;

    // chunk-start truncation keeps the high byte
    localparam logic [SAMPLE_W-1:0] PRED_KEEP_MASK = 16'hFF00;
    localparam logic signed [SUM_W-1:0] PRED_MIN = -18'sd32768;
    localparam logic signed [SUM_W-1:0] PRED_MAX = 18'sd32767;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // classified item handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       ch;
        logic                       trunc;
    } item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_SQUARE,
        BK_GUARD
    } back_state_t;

    // lowest magnitude that maps to root index k (ties go to the lower root)
    function automatic logic [SQ_W-1:0] root_thr(input logic [IDX_W-1:0] k);
        logic [SQ_W-1:0] sq;
        sq = SQ_W'(k) * SQ_W'(k);
        return sq - SQ_W'(k) + SQ_W'(1);
    endfunction

endpackage

FILE: rtl/sqdpcm_front.sv
// sqdpcm_front: input stage, holds the mode register and classifies each sample
// depends on sqdpcm_pkg
`timescale 1ns / 1ps

module sqdpcm_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] sample
    input  logic [1:0]           s_tuser,   // [0] channel, [1] chunk_start
    output logic                 q_valid,
    input  logic                 q_ready,
    output sqdpcm_pkg::item_t    q_item
);
    import sqdpcm_pkg::*;

    logic  stereo_reg;
    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic  s_xfer;

    // stage is free when empty or draining into the queue
    assign s_tready = !valid_reg || q_ready;
    assign s_xfer   = s_tvalid && s_tready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    // classify: mono always uses channel 0 and never truncates
    always_comb begin
        item_next.sample = s_tdata;
        item_next.ch     = stereo_reg & s_tuser[0];
        item_next.trunc  = stereo_reg & s_tuser[1];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stereo_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                stereo_reg <= cfg_wr_data;
            end
            if (s_xfer) begin
                valid_reg <= 1'b1;
            end else if (q_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: rtl/sqdpcm_queue.sv
// sqdpcm_queue: small fifo of classified items between front and back
// depends on sqdpcm_pkg
`timescale 1ns / 1ps

module sqdpcm_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sqdpcm_pkg::item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sqdpcm_pkg::item_t    out_item
);
    import sqdpcm_pkg::*;

    item_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] cnt_reg;
    logic                   push;
    logic                   pop;

    assign in_ready  = cnt_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/sqdpcm_back.sv
// sqdpcm_back: predictor state, square-root search, range guard and output register
// depends on sqdpcm_pkg
`timescale 1ns / 1ps

module sqdpcm_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  sqdpcm_pkg::item_t    q_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata    // [7:0] code, [23:8] new_predictor
);
    import sqdpcm_pkg::*;

    back_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0]        pred_reg [2];
    logic                       ch_reg;
    logic                       sign_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic [BIT_W-1:0]           bit_reg;
    logic [IDX_W-1:0]           res_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic                       out_valid_reg;
    logic [CODE_W-1:0]          code_reg;
    logic [SAMPLE_W-1:0]        npred_reg;

    logic                       pop;
    logic [SAMPLE_W-1:0]        pred_sel;
    logic [SAMPLE_W-1:0]        prev_in;
    logic signed [MAG_W-1:0]    diff;
    logic [MAG_W-1:0]           mag_in;
    logic [IDX_W-1:0]           cand;
    logic                       take;
    logic                       big;
    logic signed [SUM_W-1:0]    prev_ext;
    logic signed [SUM_W-1:0]    sum_first;
    logic                       ovf;
    logic [IDX_W-1:0]           idx_fin;
    logic [SQ_W-1:0]            sq_fin;
    logic signed [SUM_W-1:0]    sum_fin;
    logic                       out_load;

    // difference against the (possibly truncated) channel predictor
    always_comb begin
        pop      = (state_reg == BK_IDLE) && q_valid;
        pred_sel = pred_reg[q_item.ch];
        prev_in  = q_item.trunc ? (pred_sel & PRED_KEEP_MASK) : pred_sel;
        diff     = {q_item.sample[SAMPLE_W-1], q_item.sample}
                 - {prev_in[SAMPLE_W-1], prev_in};
        mag_in   = diff[MAG_W-1] ? MAG_W'(~diff + 1'b1) : MAG_W'(diff);
    end

    // one root bit per cycle, msb first
    always_comb begin
        cand = res_reg | (IDX_W'(1) << bit_reg);
        take = {{(MAG_W - SQ_W){1'b0}}, root_thr(cand)} <= mag_reg;
        big  = (mag_reg >= MAX_DIFF) || (mag_reg >= ROOT_CLAMP_THR);
    end

    // range guard: lower the root once if the step would leave 16 bits
    always_comb begin
        prev_ext  = SUM_W'(prev_reg);
        sum_first = sign_reg ? prev_ext - SUM_W'(sq_reg) : prev_ext + SUM_W'(sq_reg);
        ovf       = ((sum_first < PRED_MIN) || (sum_first > PRED_MAX)) && (idx_reg != '0);
        idx_fin   = ovf ? idx_reg - 1'b1 : idx_reg;
        sq_fin    = ovf ? sq_reg - {{(SQ_W - IDX_W - 1){1'b0}}, idx_reg, 1'b0} + SQ_W'(1)
                        : sq_reg;
        sum_fin   = sign_reg ? prev_ext - SUM_W'(sq_fin) : prev_ext + SUM_W'(sq_fin);
        out_load  = (state_reg == BK_GUARD) && (!out_valid_reg || m_tready);
    end

    // sequencer next state and outputs
    always_comb begin
        state_next = state_reg;
        q_ready    = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    state_next = BK_SEARCH;
                end
            end
            BK_SEARCH: begin
                if (bit_reg == '0) begin
                    state_next = BK_SQUARE;
                end
            end
            BK_SQUARE: begin
                state_next = BK_GUARD;
            end
            BK_GUARD: begin
                if (out_load) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {npred_reg, code_reg};

    // state, predictors and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            pred_reg[0]   <= '0;
            pred_reg[1]   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop && q_item.trunc) begin
                pred_reg[0] <= pred_reg[0] & PRED_KEEP_MASK;
                pred_reg[1] <= pred_reg[1] & PRED_KEEP_MASK;
            end
            if (out_load) begin
                pred_reg[ch_reg] <= sum_fin[SAMPLE_W-1:0];
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            ch_reg   <= q_item.ch;
            sign_reg <= diff[MAG_W-1];
            mag_reg  <= mag_in;
            prev_reg <= prev_in;
            res_reg  <= '0;
            bit_reg  <= BIT_W'(IDX_W - 1);
        end
        if (state_reg == BK_SEARCH) begin
            if (take) begin
                res_reg <= cand;
            end
            bit_reg <= bit_reg - 1'b1;
        end
        if (state_reg == BK_SQUARE) begin
            idx_reg <= big ? IDX_MAX : res_reg;
            sq_reg  <= big ? SQ_W'(IDX_MAX) * SQ_W'(IDX_MAX)
                           : SQ_W'(res_reg) * SQ_W'(res_reg);
        end
        if (out_load) begin
            code_reg  <= {sign_reg, idx_fin};
            npred_reg <= sum_fin[SAMPLE_W-1:0];
        end
    end

    // partial root never overshoots the magnitude
    a_search_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SEARCH) && (res_reg != '0)
        |-> ({{(MAG_W - SQ_W){1'b0}}, root_thr(res_reg)} <= mag_reg))
        else $error("root search passed the magnitude");

    // guarded step always stays inside 16-bit range
    a_guard_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> ((sum_fin >= PRED_MIN) && (sum_fin <= PRED_MAX)))
        else $error("predictor step left 16-bit range");

    // stored predictor matches the emitted one
    a_pred_written: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (pred_reg[ch_reg] == npred_reg))
        else $error("predictor store disagrees with output");

endmodule

FILE: rtl/square_step_dpcm_audio_encoder.sv
// square_step_dpcm_audio_encoder: samples pass the front register, the queue and
// the back end sequencer, which handles one sample at a time (load, 7 root-search
// steps of one bit each, square, guard) and pops the next once the result is
// loaded. the 2-entry queue lets the front take samples while the back is busy.
// reset (aresetn low, synchronous) zeroes both predictors, selects mono, empties
// the queue and the output register; no clearing pass is needed.
`timescale 1ns / 1ps

module square_step_dpcm_audio_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,  // stereo_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [15:0] sample
    input  logic [1:0]  s_tuser,      // [0] channel, [1] chunk_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata       // [7:0] code, [23:8] new_predictor
);
    import sqdpcm_pkg::*;

    logic  fq_valid;
    logic  fq_ready;
    item_t fq_item;
    logic  qb_valid;
    logic  qb_ready;
    item_t qb_item;

    // accept and classify
    sqdpcm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_item      (fq_item)
    );

    // decoupling queue
    sqdpcm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // encode and update predictor
    sqdpcm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_item   (qb_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
